[rtl/core/iasc_pkg.sv]
// shared types and constants for the idle-air stepper controller
// no dependencies; used by iasc_ctrl, iasc_dp and the top level
package iasc_pkg;

  localparam int unsigned RegW   = 8;
  localparam int unsigned IndexW = 3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_HOME   = 2'd1,
    OP_TARGET = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STEP_NONE  = 2'd0,
    STEP_OPEN  = 2'd1,
    STEP_CLOSE = 2'd2,
    STEP_RSVD  = 2'd3
  } step_t;

  typedef enum logic [IndexW-1:0] {
    REG_POS_MIN   = 3'd0,
    REG_POS_MAX   = 3'd1,
    REG_COLD_POS  = 3'd2,
    REG_WARM_POS  = 3'd3,
    REG_DAMPER    = 3'd4,
    REG_UNUSED_5  = 3'd5,
    REG_UNUSED_6  = 3'd6,
    REG_UNUSED_7  = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_MUL_MAG,
    ST_COMMIT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul_sq;
    logic mul_mag;
    logic commit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

[rtl/core/iasc_ctrl.sv]
// sequencing state machine for the idle-air stepper controller
// depends on iasc_pkg; drives iasc_dp through cmd_t and reads status_t
module iasc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  iasc_pkg::status_t status,
  output iasc_pkg::cmd_t    cmd
);

  iasc_pkg::state_t state;
  iasc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iasc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iasc_pkg::ST_IDLE: begin
        if (in_valid) state_next = iasc_pkg::ST_MUL_SQ;
      end
      iasc_pkg::ST_MUL_SQ:  state_next = iasc_pkg::ST_MUL_MAG;
      iasc_pkg::ST_MUL_MAG: state_next = iasc_pkg::ST_COMMIT;
      iasc_pkg::ST_COMMIT: begin
        // wait until the output register can take a new word
        if (!status.out_busy) state_next = iasc_pkg::ST_IDLE;
      end
      default: state_next = iasc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      iasc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      iasc_pkg::ST_MUL_SQ:  cmd.mul_sq  = 1'b1;
      iasc_pkg::ST_MUL_MAG: cmd.mul_mag = 1'b1;
      iasc_pkg::ST_COMMIT:  cmd.commit  = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/iasc_dp.sv]
// datapath: configuration, stepper state, start-position multiplies, output word
// depends on iasc_pkg; sequenced by iasc_ctrl
module iasc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  iasc_pkg::cmd_t                cmd,
  output iasc_pkg::status_t             status,
  input  logic                          wr_en,
  input  logic [iasc_pkg::IndexW-1:0]   wr_index,
  input  logic [iasc_pkg::RegW-1:0]     wr_data,
  input  logic [1:0]                    operation,
  input  logic [7:0]                    coolant,
  input  logic                          engine_running,
  input  logic                          idle_mode,
  input  logic [7:0]                    target,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          line_a,
  output logic                          line_b,
  output logic [7:0]                    position,
  output logic [1:0]                    step_taken,
  output logic                          start_phase_active,
  output logic                          homing_busy
);

  typedef struct packed {
    logic [7:0] pc;
    logic       a;
    logic       b;
    logic [1:0] step;
  } move_t;

  // configuration
  logic [7:0] pos_min, pos_max, cold_start_pos, warm_start_pos, damper_pos;

  // stepper state
  logic [7:0] pos_count;
  logic       phase_a, phase_b, start_armed;
  logic [7:0] homing_left;

  // captured word and multiply results
  logic [1:0] op_q;
  logic [7:0] coolant_q, target_q;
  logic       running_q, idle_q;
  logic [7:0] sq;
  logic [15:0] mag;

  logic       out_valid_q;

  function automatic move_t open_step(move_t m, logic [7:0] hi);
    move_t r;
    r = m;
    if (m.pc < hi) begin
      r.pc   = m.pc + 8'd1;
      // gray walk 00 -> 10 -> 11 -> 01 -> 00
      r.a    = !m.b;
      r.b    = m.a;
      r.step = iasc_pkg::STEP_OPEN;
    end
    return r;
  endfunction

  function automatic move_t close_step(move_t m, logic [7:0] lo);
    move_t r;
    r = m;
    if (m.pc > lo) begin
      r.pc   = m.pc - 8'd1;
      // reverse walk 00 -> 01 -> 11 -> 10 -> 00
      r.a    = m.b;
      r.b    = !m.a;
      r.step = iasc_pkg::STEP_CLOSE;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_min        <= 8'd0;
      pos_max        <= 8'd200;
      cold_start_pos <= 8'd120;
      warm_start_pos <= 8'd40;
      damper_pos     <= 8'd60;
    end else if (wr_en) begin
      case (iasc_pkg::reg_index_t'(wr_index))
        iasc_pkg::REG_POS_MIN:  pos_min        <= wr_data;
        iasc_pkg::REG_POS_MAX:  pos_max        <= wr_data;
        iasc_pkg::REG_COLD_POS: cold_start_pos <= wr_data;
        iasc_pkg::REG_WARM_POS: warm_start_pos <= wr_data;
        iasc_pkg::REG_DAMPER:   damper_pos     <= wr_data;
        default: ;
      endcase
    end
  end

  // signed difference of the two start positions, kept as sign and magnitude
  logic [8:0]  diff;
  logic        diff_neg;
  logic [7:0]  diff_mag;
  logic [15:0] sq_full;
  logic [16:0] mag_rnd;
  logic [7:0]  start_pos;

  assign diff     = {1'b0, cold_start_pos} - {1'b0, warm_start_pos};
  assign diff_neg = diff[8];
  assign diff_mag = diff_neg ? 8'(-diff) : diff[7:0];
  assign sq_full  = 16'(coolant_q) * 16'(coolant_q);
  assign mag_rnd  = {1'b0, mag} + 17'd255;
  // floor toward minus infinity on the falling side
  assign start_pos = diff_neg ? (warm_start_pos - mag_rnd[15:8])
                              : (warm_start_pos + mag[15:8]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= operation;
      coolant_q <= coolant;
      running_q <= engine_running;
      idle_q    <= idle_mode;
      target_q  <= target;
    end
    if (cmd.mul_sq) sq <= sq_full[15:8];
    if (cmd.mul_mag) mag <= 16'(sq) * 16'(diff_mag);
  end

  move_t      mv;
  logic       arm_next;
  logic [7:0] homing_left_next;

  always_comb begin
    mv               = '{pc: pos_count, a: phase_a, b: phase_b, step: iasc_pkg::STEP_NONE};
    arm_next         = start_armed;
    homing_left_next = homing_left;
    if (op_q == iasc_pkg::OP_HOME) begin
      homing_left_next = pos_max;
      if (pos_max == 8'd0) begin
        mv.pc    = 8'd0;
        arm_next = 1'b1;
      end
    end
    if (homing_left_next != 8'd0) begin
      mv.pc            = pos_max;
      mv               = close_step(mv, pos_min);
      homing_left_next = homing_left_next - 8'd1;
      if (homing_left_next == 8'd0) begin
        mv.pc    = 8'd0;
        arm_next = 1'b1;
      end
    end else if (op_q == iasc_pkg::OP_TICK) begin
      if (start_armed) begin
        if (start_pos > mv.pc) mv = open_step(mv, pos_max);
        else arm_next = 1'b0;
      end else if (running_q && !idle_q) begin
        if (damper_pos > mv.pc) mv = open_step(mv, pos_max);
      end
    end else if (op_q == iasc_pkg::OP_TARGET) begin
      if (target_q > mv.pc) mv = open_step(mv, pos_max);
      else if (target_q < mv.pc) mv = close_step(mv, pos_min);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count   <= 8'd0;
      phase_a     <= 1'b0;
      phase_b     <= 1'b0;
      start_armed <= 1'b0;
      homing_left <= 8'd0;
    end else if (cmd.commit) begin
      pos_count   <= mv.pc;
      phase_a     <= mv.a;
      phase_b     <= mv.b;
      start_armed <= arm_next;
      homing_left <= homing_left_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      line_a             <= mv.a;
      line_b             <= mv.b;
      position           <= mv.pc;
      step_taken         <= mv.step;
      start_phase_active <= arm_next;
      homing_busy        <= (homing_left_next != 8'd0);
    end
  end

  assign out_valid       = out_valid_q;
  assign status.out_busy = out_valid_q && out_stall;

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid_q)
    else $error("output word not marked valid after commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid_q || !out_stall))
    else $error("pending output word overwritten");

  a_word_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid_q |-> (position == pos_count && line_a == phase_a &&
                     line_b == phase_b && start_phase_active == start_armed &&
                     homing_busy == (homing_left != 8'd0)))
    else $error("output word disagrees with stepper state");

  a_step_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid_q |-> step_taken != iasc_pkg::STEP_RSVD)
    else $error("reserved step code in output word");

endmodule

[rtl/core/idle_air_stepper_controller_top.sv]
// idle-air stepper controller: two-phase full-step sequencer with homing
// depends on iasc_pkg, iasc_ctrl and iasc_dp
//
// usage:
//   input channel (in_valid/in_stall) carries one word per command: a
//   regulation tick, a homing start or a step toward target. every accepted
//   word yields exactly one output word on out_valid/out_stall with the
//   phase line levels, position count, step taken and status flags.
//   configuration registers are written through wr_en/wr_index/wr_data
//   while the block is idle; indexes past the register list are ignored.
// timing:
//   a word is worked in order: capture, coolant square, start-position multiply,
//   then commit into the state and output register. the two multiplies are
//   chained. one word is in work at a time: the next word is taken only
//   after the last one has been committed.
// reset and stall:
//   rst (synchronous) restores the register defaults and zeroes position,
//   phases, start-phase arm and homing count. a stalled output word holds;
//   the next word may be taken and worked meanwhile, and waits at commit
//   until the output register is free.
module idle_air_stepper_controller_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [iasc_pkg::IndexW-1:0] wr_index,
  input  logic [iasc_pkg::RegW-1:0]   wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [7:0]                  coolant,
  input  logic                        engine_running,
  input  logic                        idle_mode,
  input  logic [7:0]                  target,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        line_a,
  output logic                        line_b,
  output logic [7:0]                  position,
  output logic [1:0]                  step_taken,
  output logic                        start_phase_active,
  output logic                        homing_busy
);

  iasc_pkg::cmd_t    cmd;
  iasc_pkg::status_t status;

  iasc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  iasc_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data),
    .operation          (operation),
    .coolant            (coolant),
    .engine_running     (engine_running),
    .idle_mode          (idle_mode),
    .target             (target),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .line_a             (line_a),
    .line_b             (line_b),
    .position           (position),
    .step_taken         (step_taken),
    .start_phase_active (start_phase_active),
    .homing_busy        (homing_busy)
  );

endmodule
